### sv/spilhc_pkg.sv
// types, codes and helpers shared by the spi link handshake controller
`default_nettype none

package spilhc_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // action codes
  localparam logic [1:0] ACT_DONE  = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  // response codes
  localparam logic [2:0] RC_SUCCESS  = 3'd0;
  localparam logic [2:0] RC_BAD_RESP = 3'd1;
  localparam logic [2:0] RC_BAD_HCRC = 3'd2;
  localparam logic [2:0] RC_FORMAT   = 3'd3;
  localparam logic [2:0] RC_VERSION  = 3'd4;
  localparam logic [2:0] RC_LENGTH   = 3'd5;
  localparam logic [2:0] RC_BAD_DCRC = 3'd6;

  // phase codes as reported on the result word
  localparam logic [2:0] PC_HEADER    = 3'd0;
  localparam logic [2:0] PC_HDR_RESP  = 3'd1;
  localparam logic [2:0] PC_DATA      = 3'd2;
  localparam logic [2:0] PC_DATA_RESP = 3'd3;
  localparam logic [2:0] PC_RESETTING = 3'd4;
  localparam logic [2:0] PC_PROCESS   = 3'd5;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FORMAT  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_VERSION = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LEN = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 2'd3;

  typedef enum logic [5:0] {
    PH_HEADER    = 6'b000001,
    PH_HDR_RESP  = 6'b000010,
    PH_DATA      = 6'b000100,
    PH_DATA_RESP = 6'b001000,
    PH_RESETTING = 6'b010000,
    PH_PROCESS   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  peer_response;
    logic [7:0]  peer_format;
    logic [7:0]  peer_version;
    logic [15:0] peer_length_in;
    logic        header_crc_ok;
    logic        data_crc_ok;
    logic [15:0] own_length_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  next_phase;
    logic [2:0]  response_sent;
    logic [15:0] exchange_bytes;
    logic        data_ready;
    logic [15:0] failure_total;
    logic [15:0] sequence_number;
  } out_item_t;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_HEADER:    code = PC_HEADER;
      PH_HDR_RESP:  code = PC_HDR_RESP;
      PH_DATA:      code = PC_DATA;
      PH_DATA_RESP: code = PC_DATA_RESP;
      PH_RESETTING: code = PC_RESETTING;
      PH_PROCESS:   code = PC_PROCESS;
      default:      code = PC_HEADER;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

### sv/spilhc_if.sv
// valid/ready channel interfaces for input and result words
`default_nettype none

interface spilhc_in_if;
  import spilhc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface spilhc_out_if;
  import spilhc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### sv/spilhc_ctrl.sv
// link state, configuration registers and per-word next-state logic
`default_nettype none

module spilhc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  spilhc_pkg::cfg_wr_t   cfg,
  input  logic                  step,
  input  spilhc_pkg::in_item_t  item,
  output spilhc_pkg::out_item_t result
);
  import spilhc_pkg::*;

  logic [7:0]  format_code;
  logic [7:0]  protocol_version;
  logic [15:0] max_data_length;
  logic [15:0] timeout_ticks;

  phase_t      link_phase, link_phase_next;
  logic [2:0]  sent_response, sent_response_next;
  logic [15:0] peer_length, peer_length_next;
  logic [15:0] own_length, own_length_next;
  logic [15:0] idle_ticks, idle_ticks_next;
  logic [15:0] failure_count, failure_count_next;
  logic [15:0] sequence_count, sequence_count_next;

  logic        count_fail;
  logic        ready_flag;
  logic [15:0] idle_inc;
  logic [15:0] longer_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_code      <= 8'd0;
      protocol_version <= 8'd0;
      max_data_length  <= 16'd8192;
      timeout_ticks    <= 16'd500;
    end else if (cfg.we) begin
      case (cfg.index)
        CFG_FORMAT:  format_code      <= cfg.data[7:0];
        CFG_VERSION: protocol_version <= cfg.data[7:0];
        CFG_MAX_LEN: max_data_length  <= cfg.data;
        CFG_TIMEOUT: timeout_ticks    <= cfg.data;
        default: ;
      endcase
    end
  end

  assign idle_inc = (idle_ticks == 16'hFFFF) ? idle_ticks : idle_ticks + 16'd1;

  always_comb begin
    link_phase_next     = link_phase;
    sent_response_next  = sent_response;
    peer_length_next    = peer_length;
    own_length_next     = own_length;
    idle_ticks_next     = idle_ticks;
    sequence_count_next = sequence_count;
    count_fail          = 1'b0;
    ready_flag          = 1'b0;
    case (item.action)
      ACT_DONE: begin
        idle_ticks_next = 16'd0;
        case (link_phase)
          PH_HEADER: begin
            if (item.peer_response == RC_BAD_RESP) begin
              count_fail = 1'b1;
            end else begin
              peer_length_next = item.peer_length_in;
              if (!item.header_crc_ok) sent_response_next = RC_BAD_HCRC;
              else if (item.peer_format != format_code) sent_response_next = RC_FORMAT;
              else if (item.peer_version != protocol_version) sent_response_next = RC_VERSION;
              else if (item.peer_length_in > max_data_length) sent_response_next = RC_LENGTH;
              else sent_response_next = RC_SUCCESS;
              link_phase_next = PH_HDR_RESP;
            end
          end
          PH_HDR_RESP: begin
            if (item.peer_response == RC_SUCCESS && sent_response == RC_SUCCESS) begin
              link_phase_next = (peer_length != 16'd0 || own_length != 16'd0) ?
                                PH_DATA : PH_HEADER;
            end else if (item.peer_response == RC_BAD_RESP) begin
              count_fail      = 1'b1;
              link_phase_next = PH_HEADER;
            end else if (item.peer_response == RC_BAD_HCRC ||
                         sent_response == RC_BAD_HCRC) begin
              link_phase_next = PH_HEADER;
            end else begin
              count_fail         = 1'b1;
              sent_response_next = RC_BAD_RESP;
              link_phase_next    = PH_RESETTING;
            end
          end
          PH_DATA: begin
            if (item.peer_response == RC_BAD_RESP) begin
              link_phase_next = PH_HEADER;
            end else begin
              sent_response_next = item.data_crc_ok ? RC_SUCCESS : RC_BAD_DCRC;
              link_phase_next    = PH_DATA_RESP;
            end
          end
          PH_DATA_RESP: begin
            if (item.peer_response == RC_SUCCESS && sent_response == RC_SUCCESS) begin
              link_phase_next = PH_PROCESS;
              ready_flag      = 1'b1;
            end else if (item.peer_response == RC_BAD_RESP) begin
              count_fail      = 1'b1;
              link_phase_next = PH_HEADER;
            end else if (item.peer_response == RC_BAD_DCRC ||
                         sent_response == RC_BAD_DCRC) begin
              link_phase_next = PH_DATA;
            end else begin
              count_fail         = 1'b1;
              sent_response_next = RC_BAD_RESP;
              link_phase_next    = PH_RESETTING;
            end
          end
          default: link_phase_next = PH_HEADER;
        endcase
      end
      ACT_TICK: begin
        idle_ticks_next = idle_inc;
        if (link_phase != PH_HEADER && idle_inc > timeout_ticks) begin
          link_phase_next = PH_HEADER;
        end
      end
      ACT_START: begin
        own_length_next     = item.own_length_in;
        peer_length_next    = 16'd0;
        sequence_count_next = sequence_count + 16'd1;
        link_phase_next     = PH_HEADER;
      end
      default: ;
    endcase
    failure_count_next = (count_fail && failure_count != 16'hFFFF) ?
                         failure_count + 16'd1 : failure_count;
  end

  assign longer_length = (peer_length_next > own_length_next) ?
                         peer_length_next : own_length_next;

  always_comb begin
    result.next_phase      = phase_code(link_phase_next);
    result.response_sent   = sent_response_next;
    result.exchange_bytes  = (link_phase_next == PH_DATA) ? longer_length : 16'd0;
    result.data_ready      = ready_flag;
    result.failure_total   = failure_count_next;
    result.sequence_number = sequence_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_phase     <= PH_DATA;
      sent_response  <= RC_SUCCESS;
      peer_length    <= 16'd0;
      own_length     <= 16'd0;
      idle_ticks     <= 16'd0;
      failure_count  <= 16'd0;
      sequence_count <= 16'd0;
    end else if (step) begin
      link_phase     <= link_phase_next;
      sent_response  <= sent_response_next;
      peer_length    <= peer_length_next;
      own_length     <= own_length_next;
      idle_ticks     <= idle_ticks_next;
      failure_count  <= failure_count_next;
      sequence_count <= sequence_count_next;
    end
  end

  a_ready_enters_process: assert property (@(posedge clk) disable iff (rst)
    (step && result.data_ready) |=> link_phase == PH_PROCESS)
    else $error("data_ready without entering processing phase");

  a_fail_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> failure_count >= $past(failure_count))
    else $error("failure count decreased");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(link_phase) && $stable(sequence_count) && $stable(failure_count))
    else $error("state changed without a word");

  a_seq_on_start: assert property (@(posedge clk) disable iff (rst)
    (step && item.action == ACT_START) |=>
      sequence_count == 16'($past(sequence_count) + 16'd1) && link_phase == PH_HEADER)
    else $error("start next did not advance sequence");

endmodule

`default_nettype wire

### sv/spi_link_handshake_control_core.sv
// top level: input register, handshake control and result register
// Slave-side handshake controller for a header / header response / data /
// data response link exchange. Each input word carries one event (transfer
// finished, millisecond tick or start next) and produces exactly one result
// word with the next phase, the response being sent, the data phase length,
// the ready flag, the failure count and the sequence number.
// Channels: in_ch (sink) and out_ch (source), valid/ready; a word moves on a
// clock edge with valid and ready both high. cfg_we/cfg_index/cfg_data write
// the four configuration registers; the user must write them only while no
// word is in flight; the block itself does not enforce this. A word taken on
// in_ch is held in the input register and its result in the result register.
// Throughput: one word per cycle while out_ch does not stall, set by the
// combinational next-state logic between the input and result registers.
// Reset (rst, synchronous): both stages empty, phase is data, counters zero,
// configuration back to its defaults.
// When out_ch stalls the result holds, the input register keeps its word,
// and in_ch drops ready once both stages are full.
`default_nettype none

module spi_link_handshake_control_core (
  input  logic                                clk,
  input  logic                                rst,
  spilhc_in_if.sink                           in_ch,
  spilhc_out_if.source                        out_ch,
  input  logic                                cfg_we,
  input  logic [spilhc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [spilhc_pkg::CfgDataW-1:0]     cfg_data
);
  import spilhc_pkg::*;

  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_adv;
  logic      step;
  out_item_t result;
  logic      out_valid;
  out_item_t out_item;
  cfg_wr_t   cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign s1_adv      = !out_valid || out_ch.ready;
  assign in_ch.ready = !s1_valid || s1_adv;
  assign step        = s1_valid && s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item <= in_ch.payload;
    end
  end

  spilhc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (step),
    .item   (s1_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= result;
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

endmodule

`default_nettype wire
